// File: sv/brightness_contrast_pixel_map_defines.svh
// Assertion macros for the pixel map.
`ifndef BRIGHTNESS_CONTRAST_PIXEL_MAP_DEFINES_SVH
`define BRIGHTNESS_CONTRAST_PIXEL_MAP_DEFINES_SVH

`define BCPM_ASSERT_NOW(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define BCPM_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// File: sv/bcpm_pkg.sv
package bcpm_pkg;

  localparam int unsigned DIV_STAGES = 16;
  localparam int unsigned LANES = 4;

  localparam logic [2:0] REG_BRIGHTNESS   = 3'd0;
  localparam logic [2:0] REG_CONTRAST     = 3'd1;
  localparam logic [2:0] REG_RED_ENABLE   = 3'd2;
  localparam logic [2:0] REG_GREEN_ENABLE = 3'd3;
  localparam logic [2:0] REG_BLUE_ENABLE  = 3'd4;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd5;

  localparam logic FORMAT_RGB888 = 1'b0;
  localparam logic FORMAT_RGB565 = 1'b1;

  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] dq;
  } lane_t;

  // One restoring division step: the dividend shifts out of dq as the
  // quotient shifts in.
  function automatic lane_t div_step(lane_t l, logic [8:0] m);
    logic [8:0] t;
    logic [8:0] d;
    lane_t      r;
    t = {l.rem, l.dq[15]};
    d = t - m;
    r.rem = (t >= m) ? d[7:0] : t[7:0];
    r.dq  = {l.dq[14:0], (t >= m)};
    return r;
  endfunction

  function automatic logic [7:0] clamp_sum(logic signed [17:0] s);
    logic [7:0] r;
    if (s < 18'sd0) begin
      r = 8'd0;
    end else if (s > 18'sd255) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

// File: sv/brightness_contrast_pixel_map.sv
// Brightness and contrast map for one pixel a beat, RGB888 or RGB565.
// Input channel: in_valid, in_stall, pixel_in. Output channel: out_valid,
// out_stall, pixel_out. A beat moves when valid is high and stall is low.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the stream is idle, since the block does not
// enforce this. The registers follow the list brightness, contrast, red,
// green and blue enables, pixel format. Other indexes are ignored.
// An accepted input beat passes the entry register, loaded at the accepting
// edge, then sixteen stages of a pipelined restoring divider (one quotient
// bit a stage, four lanes) and the output register on its way to pixel_out.
// Throughput is one pixel per cycle while the output is not stalled.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// in_stall goes high, so nothing is lost or repeated.
// Reset clears all valid bits and sets brightness and contrast to zero, all
// channels enabled and the RGB888 format.
`include "brightness_contrast_pixel_map_defines.svh"

module brightness_contrast_pixel_map
  import bcpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] pixel_out,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic signed [8:0] brightness;
  logic signed [7:0] contrast;
  logic              red_enable;
  logic              green_enable;
  logic              blue_enable;
  logic              pixel_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= '0;
      contrast     <= '0;
      red_enable   <= 1'b1;
      green_enable <= 1'b1;
      blue_enable  <= 1'b1;
      pixel_format <= FORMAT_RGB888;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BRIGHTNESS:   brightness   <= cfg_data;
        REG_CONTRAST:     contrast     <= cfg_data[7:0];
        REG_RED_ENABLE:   red_enable   <= cfg_data[0];
        REG_GREEN_ENABLE: green_enable <= cfg_data[0];
        REG_BLUE_ENABLE:  blue_enable  <= cfg_data[0];
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic       adv;
  logic       neg;
  logic [8:0] divisor;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign neg      = contrast[7];
  assign divisor  = neg ? 9'd128 : (9'd256 - {1'b0, contrast[6:0], 1'b0});

  logic [7:0]  chan [3];
  logic [15:0] dividend [LANES];
  logic [7:0]  neg_k;

  always_comb begin
    if (pixel_format == FORMAT_RGB888) begin
      chan[0] = pixel_in[23:16];
      chan[1] = pixel_in[15:8];
      chan[2] = pixel_in[7:0];
    end else begin
      chan[0] = {pixel_in[15:11], 3'b000};
      chan[1] = {pixel_in[10:5], 2'b00};
      chan[2] = {pixel_in[4:0], 3'b000};
    end
    neg_k = 8'(-contrast);
    for (int i = 0; i < 3; i++) begin
      dividend[i] = neg ? {1'b0, 15'(chan[i]) * 15'(contrast[6:0])}
                        : {chan[i], 8'd0};
    end
    dividend[3] = neg ? {1'b0, neg_k, 7'd0} : {1'b0, contrast[6:0], 8'd0};
  end

  logic        valid_q [DIV_STAGES+1];
  lane_t       lane_q  [DIV_STAGES+1][LANES];
  logic [23:0] pix_q   [DIV_STAGES+1];
  logic        neg_q   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= in_valid;
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_q[s+1] <= valid_q[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_q[0] <= pixel_in;
      neg_q[0] <= neg;
      for (int l = 0; l < LANES; l++) begin
        lane_q[0][l].rem <= '0;
        lane_q[0][l].dq  <= dividend[l];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        pix_q[s+1] <= pix_q[s];
        neg_q[s+1] <= neg_q[s];
        for (int l = 0; l < LANES; l++) begin
          lane_q[s+1][l] <= div_step(lane_q[s][l], divisor);
        end
      end
    end
  end

  logic signed [17:0] sum [3];
  logic [7:0]         mapped [3];
  logic signed [17:0] kterm;
  logic [23:0]        pix_last;
  logic [23:0]        pixel_next;

  always_comb begin
    pix_last = pix_q[DIV_STAGES];
    kterm = $signed({2'b00, lane_q[DIV_STAGES][3].dq});
    for (int i = 0; i < 3; i++) begin
      sum[i] = $signed({2'b00, lane_q[DIV_STAGES][i].dq})
             + (neg_q[DIV_STAGES] ? kterm : -kterm)
             + 18'(brightness);
      mapped[i] = clamp_sum(sum[i]);
    end
    if (pixel_format == FORMAT_RGB888) begin
      pixel_next[23:16] = red_enable   ? mapped[0] : pix_last[23:16];
      pixel_next[15:8]  = green_enable ? mapped[1] : pix_last[15:8];
      pixel_next[7:0]   = blue_enable  ? mapped[2] : pix_last[7:0];
    end else begin
      pixel_next[23:16] = 8'd0;
      pixel_next[15:11] = red_enable   ? mapped[0][7:3] : pix_last[15:11];
      pixel_next[10:5]  = green_enable ? mapped[1][7:2] : pix_last[10:5];
      pixel_next[4:0]   = blue_enable  ? mapped[2][7:3] : pix_last[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out <= pixel_next;
    end
  end

  `BCPM_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
    "in_stall without a blocked output")
  `BCPM_ASSERT_NEXT(a_pipe_holds, in_stall,
    $stable(valid_q[DIV_STAGES]) && $stable(pix_q[DIV_STAGES]), "pipeline moved during stall")
  `BCPM_ASSERT_NOW(a_565_upper_zero, out_valid && pixel_format == FORMAT_RGB565,
    pixel_out[23:16] == 8'd0, "RGB565 upper byte not clear")
  `BCPM_ASSERT_NEXT(a_last_to_out, adv && valid_q[DIV_STAGES], out_valid,
    "last stage beat not delivered")

endmodule
